>>> rtl/core/med_pkg.sv
// Package for the markup entity decoder: handshake types between the controller
// and the datapath, character codes and the small lookup functions for entity
// names and UTF-8 encoding. Depends on nothing.
`timescale 1ns / 1ps

package med_pkg;

	// Character codes that steer the match.
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;

	// UTF-8 length boundaries.
	localparam logic [31:0] UTF_LIM1 = 32'h0000_0080;
	localparam logic [31:0] UTF_LIM2 = 32'h0000_0800;
	localparam logic [31:0] UTF_LIM3 = 32'h0001_0000;
	localparam logic [31:0] UTF_MAX  = 32'h0010_FFFF;

	// What the current input byte does to the match.
	typedef enum logic [2:0] {
		CL_EMIT_B,
		CL_HOLD,
		CL_NAMED,
		CL_NUM,
		CL_FAIL
	} class_t;

	// Source of the next output byte.
	typedef enum logic [2:0] {
		OS_BYTE,
		OS_NAMED,
		OS_UTF,
		OS_HELD,
		OS_MARKER
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     step;
		logic     go_idle;
		logic     idx_clr;
		logic     idx_inc;
		logic     push;
		out_sel_t out_sel;
		logic     out_last;
	} dp_cmd_t;

	typedef struct packed {
		class_t cls;
		logic   last;
		logic   out_free;
		logic   held_end;
		logic   utf_end;
		logic   utf_none;
	} dp_stat_t;

	// Returns {valid, index} of the named entity that starts with b.
	function automatic logic [2:0] name_index(input logic [7:0] b);
		logic [2:0] r;
		unique case (b)
			8'h6C:   r = 3'b100;
			8'h67:   r = 3'b101;
			8'h61:   r = 3'b110;
			8'h71:   r = 3'b111;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] name_len(input logic [1:0] idx);
		logic [2:0] r;
		unique case (idx)
			2'd0:    r = 3'd2;
			2'd1:    r = 3'd2;
			2'd2:    r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	// Character at position pos of the entity name (position 0 is the initial).
	function automatic logic [7:0] name_text(input logic [1:0] idx, input logic [1:0] pos);
		logic [7:0] r;
		unique case ({idx, pos})
			4'b00_00: r = 8'h6C;
			4'b00_01: r = 8'h74;
			4'b01_00: r = 8'h67;
			4'b01_01: r = 8'h74;
			4'b10_00: r = 8'h61;
			4'b10_01: r = 8'h6D;
			4'b10_10: r = 8'h70;
			4'b11_00: r = 8'h71;
			4'b11_01: r = 8'h75;
			4'b11_10: r = 8'h6F;
			4'b11_11: r = 8'h74;
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] name_char(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0:    r = 8'h3C;
			2'd1:    r = 8'h3E;
			2'd2:    r = 8'h26;
			default: r = 8'h22;
		endcase
		return r;
	endfunction

	// Returns {valid, value} of a hex digit in either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end else begin
			r = 5'b0_0000;
		end
		return r;
	endfunction

	// Number of UTF-8 bytes for a code point, zero when it is out of range.
	function automatic logic [2:0] utf_len(input logic [31:0] c);
		logic [2:0] r;
		priority if (c < UTF_LIM1) begin
			r = 3'd1;
		end else if (c < UTF_LIM2) begin
			r = 3'd2;
		end else if (c < UTF_LIM3) begin
			r = 3'd3;
		end else if (c <= UTF_MAX) begin
			r = 3'd4;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf_byte(input logic [20:0] c, input logic [2:0] len,
			input logic [1:0] k);
		logic [7:0] r;
		unique case ({len, k})
			5'b001_00: r = {1'b0, c[6:0]};
			5'b010_00: r = {3'b110, c[10:6]};
			5'b010_01: r = {2'b10, c[5:0]};
			5'b011_00: r = {4'b1110, c[15:12]};
			5'b011_01: r = {2'b10, c[11:6]};
			5'b011_10: r = {2'b10, c[5:0]};
			5'b100_00: r = {5'b11110, c[20:18]};
			5'b100_01: r = {2'b10, c[17:12]};
			5'b100_10: r = {2'b10, c[11:6]};
			5'b100_11: r = {2'b10, c[5:0]};
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/med_datapath.sv
// Datapath of the markup entity decoder: input capture, held-byte store, match
// state, code point accumulator and the output register.
// Depends on med_pkg.
`timescale 1ns / 1ps

module med_datapath #(
	parameter int MAX_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  med_pkg::dp_cmd_t  cmd,
	output med_pkg::dp_stat_t stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              out_flag,
	output logic              out_last
);
	import med_pkg::*;

	localparam int HoldDepth = (MAX_DIGITS + 3 > 5) ? MAX_DIGITS + 3 : 5;
	localparam int CntW      = $clog2(HoldDepth + 1);
	localparam int IdxW      = $clog2(HoldDepth);

	typedef enum logic [2:0] {
		M_IDLE,
		M_AMP,
		M_NAMED,
		M_HASH,
		M_DEC,
		M_HEX
	} mode_t;

	logic [7:0]      byte_q;
	logic            last_q;
	logic [7:0]      held_q [HoldDepth];
	logic [CntW-1:0] cnt_q;
	mode_t           mode_q;
	logic [31:0]     acc_q;
	logic [IdxW-1:0] idx_q;
	logic            valid_q;
	logic [7:0]      obyte_q;
	logic            oflag_q;
	logic            olast_q;

	class_t          cls;
	mode_t           nxt_mode;
	logic [31:0]     nxt_acc;
	logic [2:0]      nm_in;
	logic [2:0]      nm_held;
	logic [4:0]      hx;
	logic            is_dig;
	logic [CntW-1:0] pos;
	logic [2:0]      nlen;
	logic [2:0]      ulen;
	logic            out_free;
	logic [7:0]      mux_byte;
	logic            mux_flag;

	// Classify the captured byte against the current match.
	always_comb begin
		cls      = CL_FAIL;
		nxt_mode = mode_q;
		nxt_acc  = acc_q;
		nm_in    = name_index(byte_q);
		nm_held  = name_index(held_q[1]);
		hx       = hex_digit(byte_q);
		is_dig   = (byte_q >= CH_0) && (byte_q <= CH_9);
		pos      = cnt_q - CntW'(1);
		nlen     = name_len(nm_held[1:0]);
		unique case (mode_q)
			M_IDLE: begin
				if (byte_q == CH_AMP) begin
					cls      = CL_HOLD;
					nxt_mode = M_AMP;
				end else begin
					cls = CL_EMIT_B;
				end
			end
			M_AMP: begin
				if (nm_in[2]) begin
					cls      = CL_HOLD;
					nxt_mode = M_NAMED;
				end else if (byte_q == CH_HASH) begin
					cls      = CL_HOLD;
					nxt_mode = M_HASH;
				end
			end
			M_NAMED: begin
				if (pos < CntW'(nlen)) begin
					if (byte_q == name_text(nm_held[1:0], pos[1:0])) begin
						cls = CL_HOLD;
					end
				end else if (pos == CntW'(nlen) && byte_q == CH_SEMI) begin
					cls = CL_NAMED;
				end
			end
			M_HASH: begin
				if (is_dig) begin
					cls      = CL_HOLD;
					nxt_mode = M_DEC;
					nxt_acc  = {28'd0, byte_q[3:0]};
				end else if (byte_q == CH_X) begin
					cls      = CL_HOLD;
					nxt_mode = M_HEX;
					nxt_acc  = 32'd0;
				end
			end
			M_DEC: begin
				if (is_dig) begin
					if (cnt_q < CntW'(MAX_DIGITS + 2)) begin
						cls     = CL_HOLD;
						nxt_acc = (acc_q << 3) + (acc_q << 1) + {28'd0, byte_q[3:0]};
					end
				end else if (byte_q == CH_SEMI && cnt_q > CntW'(2) && acc_q != 32'd0) begin
					cls = CL_NUM;
				end
			end
			M_HEX: begin
				if (hx[4]) begin
					if (cnt_q < CntW'(MAX_DIGITS + 3)) begin
						cls     = CL_HOLD;
						nxt_acc = {acc_q[27:0], hx[3:0]};
					end
				end else if (byte_q == CH_SEMI && cnt_q > CntW'(3) && acc_q != 32'd0) begin
					cls = CL_NUM;
				end
			end
			default: cls = CL_FAIL;
		endcase
	end

	assign ulen     = utf_len(acc_q);
	assign out_free = !valid_q || out_ready;

	always_comb begin
		mux_byte = byte_q;
		mux_flag = 1'b1;
		unique case (cmd.out_sel)
			OS_BYTE:   mux_byte = byte_q;
			OS_NAMED:  mux_byte = name_char(nm_held[1:0]);
			OS_UTF:    mux_byte = utf_byte(acc_q[20:0], ulen, idx_q[1:0]);
			OS_HELD:   mux_byte = held_q[idx_q];
			OS_MARKER: begin
				mux_byte = 8'h00;
				mux_flag = 1'b0;
			end
			default:   mux_byte = byte_q;
		endcase
	end

	always_comb begin
		stat          = '0;
		stat.cls      = cls;
		stat.last     = last_q;
		stat.out_free = out_free;
		stat.held_end = (CntW'(idx_q) + CntW'(1)) == cnt_q;
		stat.utf_end  = idx_q == (IdxW'(ulen) - IdxW'(1));
		stat.utf_none = ulen == 3'd0;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.step) begin
			held_q[cnt_q[IdxW-1:0]] <= byte_q;
		end
		if (cmd.push) begin
			obyte_q <= mux_byte;
			oflag_q <= mux_flag;
			olast_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.go_idle) begin
				cnt_q  <= '0;
				mode_q <= M_IDLE;
				acc_q  <= '0;
			end else if (cmd.step) begin
				cnt_q  <= cnt_q + CntW'(1);
				mode_q <= nxt_mode;
				acc_q  <= nxt_acc;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (cmd.push) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = obyte_q;
	assign out_flag  = oflag_q;
	assign out_last  = olast_q;

endmodule

>>> rtl/core/med_ctrl.sv
// Controller of the markup entity decoder: sequences input capture, match
// evaluation, UTF-8 output and literal replay of held bytes.
// Depends on med_pkg.
`timescale 1ns / 1ps

module med_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  med_pkg::dp_stat_t stat,
	output med_pkg::dp_cmd_t  cmd
);
	import med_pkg::*;

	typedef enum logic [2:0] {
		S_WAIT,
		S_EVAL,
		S_UTF,
		S_FREPLAY,
		S_LREPLAY
	} state_t;

	state_t state_q;
	state_t nxt;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		nxt      = state_q;
		unique case (state_q)
			S_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					nxt         = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.idx_clr = 1'b1;
				unique case (stat.cls)
					CL_EMIT_B: begin
						if (stat.out_free) begin
							cmd.push     = 1'b1;
							cmd.out_sel  = OS_BYTE;
							cmd.out_last = stat.last;
							nxt          = S_WAIT;
						end
					end
					CL_HOLD: begin
						cmd.step = 1'b1;
						nxt      = stat.last ? S_LREPLAY : S_WAIT;
					end
					CL_NAMED: begin
						if (stat.out_free) begin
							cmd.push     = 1'b1;
							cmd.out_sel  = OS_NAMED;
							cmd.out_last = stat.last;
							cmd.go_idle  = 1'b1;
							nxt          = S_WAIT;
						end
					end
					CL_NUM: begin
						if (!stat.utf_none) begin
							nxt = S_UTF;
						end else if (!stat.last) begin
							cmd.go_idle = 1'b1;
							nxt         = S_WAIT;
						end else if (stat.out_free) begin
							// Out-of-range code point at end of text: bare end marker.
							cmd.push     = 1'b1;
							cmd.out_sel  = OS_MARKER;
							cmd.out_last = 1'b1;
							cmd.go_idle  = 1'b1;
							nxt          = S_WAIT;
						end
					end
					CL_FAIL: nxt = S_FREPLAY;
					default: nxt = S_WAIT;
				endcase
			end
			S_UTF: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.out_sel  = OS_UTF;
					cmd.out_last = stat.last && stat.utf_end;
					cmd.idx_inc  = 1'b1;
					if (stat.utf_end) begin
						cmd.go_idle = 1'b1;
						nxt         = S_WAIT;
					end
				end
			end
			S_FREPLAY: begin
				if (stat.out_free) begin
					cmd.push    = 1'b1;
					cmd.out_sel = OS_HELD;
					cmd.idx_inc = 1'b1;
					if (stat.held_end) begin
						cmd.go_idle = 1'b1;
						nxt         = S_EVAL;
					end
				end
			end
			S_LREPLAY: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.out_sel  = OS_HELD;
					cmd.out_last = stat.held_end;
					cmd.idx_inc  = 1'b1;
					if (stat.held_end) begin
						cmd.go_idle = 1'b1;
						nxt         = S_WAIT;
					end
				end
			end
			default: nxt = S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
		end else begin
			state_q <= nxt;
		end
	end

endmodule

>>> rtl/core/markup_entity_decoder_core.sv
// Top level of the markup entity decoder: stream ports, controller and datapath.
// Depends on med_pkg, med_ctrl and med_datapath.
`timescale 1ns / 1ps

// Streaming decoder of markup character entities. Text bytes enter on the slave
// stream and decoded bytes leave on the master stream. The named entities for
// less-than, greater-than, ampersand and double quote become their characters,
// and decimal (&#N;) or hex (&#xH;, lower-case x) references of 1 to MAX_DIGITS
// digits become the UTF-8 bytes of the code point. Bytes of an entity in
// progress are held; if the entity turns out malformed, overlong or zero, the
// held bytes come out literally and the byte that broke the match is decoded
// afresh. A code point above 0x10FFFF is swallowed. An input transaction with
// tlast set flushes any held bytes, and the last output transaction of that text
// carries tlast; when such a byte produces no output at all, one bare end marker
// with tuser low is sent. Each input transaction is captured into a register
// and evaluated in the next cycle; no new byte is accepted during evaluation.
// Output goes through a single output register at one byte per cycle while
// m_tready keeps it free: the closing semicolon of a numeric reference is
// followed by its UTF-8 bytes, a failed match first replays its held bytes
// (up to the larger of MAX_DIGITS + 3 and five) before the breaking byte is
// evaluated again, and a byte with tlast set replays any bytes left held.
// The input is accepted whenever the decoder has finished the previous byte,
// even if the last result still waits in the output register.
module markup_entity_decoder_core #(
	parameter int MAX_DIGITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_in
	input  logic       s_tlast,   // last_in
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic       m_tuser,   // [0] byte_valid
	output logic       m_tlast    // last_out
);
	import med_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller decides the order of outputs; the datapath holds all data.
	med_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	med_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_byte  (m_tdata),
		.out_flag  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

>>> verif/med_stream_checker.sv
// Checker for the markup entity decoder: predicts the decoded byte stream from
// the accepted input transactions and compares every output transaction.
// Depends on med_pkg for the character codes and UTF-8 boundaries.
`timescale 1ns / 1ps

module med_stream_checker #(
	parameter int MAX_DIGITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] byte_in
	input  logic       s_tlast,    // last_in
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,    // [7:0] byte_out
	input  logic       m_tuser,    // [0] byte_valid
	input  logic       m_tlast,    // last_out
	output int         fail_count,
	output int         pending
);

	localparam int HOLD_DEPTH  = 11;
	localparam int STEP_MAX    = 12;
	localparam int PRINT_LIMIT = 40;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_AMP,
		MODE_NAMED,
		MODE_HASH,
		MODE_DEC,
		MODE_HEX
	} match_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} out_txn_t;

	string      entity_name [4] = '{"lt", "gt", "amp", "quot"};
	logic [7:0] entity_char [4] = '{8'h3C, 8'h3E, 8'h26, 8'h22};

	logic [7:0] held [HOLD_DEPTH];
	logic [3:0] held_cnt;
	match_t     mode;
	logic [31:0] code_acc;

	out_txn_t step_out [$];
	out_txn_t expected_bytes [$];
	int       result_no;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_LIMIT) begin
			$display("mismatch in %s of output %0d: got %h, expected %h", what, result_no, got,
				want);
		end
		fail_count++;
	endtask

	function automatic void drop_match();
		held_cnt = 4'd0;
		mode     = MODE_IDLE;
		code_acc = 32'd0;
	endfunction

	function automatic void add_step(input out_txn_t t);
		step_out = {step_out, t};
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		// Output of one input byte is capped at STEP_MAX, which the block never exceeds.
		if (step_out.size() < STEP_MAX) begin
			add_step('{b, 1'b1, 1'b0});
		end
	endfunction

	function automatic bit hold_byte(input logic [7:0] b);
		if (held_cnt >= HOLD_DEPTH) begin
			return 1'b0;
		end
		held[held_cnt] = b;
		held_cnt++;
		return 1'b1;
	endfunction

	function automatic int entity_slot(input logic [7:0] b);
		for (int i = 0; i < 4; i++) begin
			if (b == entity_name[i][0]) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int digit_value(input logic [7:0] b, input bit hex);
		if (b >= med_pkg::CH_0 && b <= med_pkg::CH_9) begin
			return int'(b - med_pkg::CH_0);
		end
		if (hex && b >= 8'h61 && b <= 8'h66) begin
			return int'(b - 8'h61) + 10;
		end
		if (hex && b >= 8'h41 && b <= 8'h46) begin
			return int'(b - 8'h41) + 10;
		end
		return -1;
	endfunction

	function automatic void put_code_point(input logic [31:0] c);
		if (c < med_pkg::UTF_LIM1) begin
			put_byte(c[7:0]);
		end else if (c < med_pkg::UTF_LIM2) begin
			put_byte({3'b110, c[10:6]});
			put_byte({2'b10, c[5:0]});
		end else if (c < med_pkg::UTF_LIM3) begin
			put_byte({4'b1110, c[15:12]});
			put_byte({2'b10, c[11:6]});
			put_byte({2'b10, c[5:0]});
		end else if (c <= med_pkg::UTF_MAX) begin
			put_byte({5'b11110, c[20:18]});
			put_byte({2'b10, c[17:12]});
			put_byte({2'b10, c[11:6]});
			put_byte({2'b10, c[5:0]});
		end
	endfunction

	// Advances the match by one byte; returns 0 when the byte breaks it.
	function automatic bit take_byte(input logic [7:0] b);
		int idx;
		int pos;
		int digits;
		int v;
		take_byte = 1'b1;
		case (mode)
			MODE_IDLE: begin
				if (b == med_pkg::CH_AMP) begin
					held_cnt = 4'd0;
					void'(hold_byte(b));
					mode = MODE_AMP;
				end else begin
					put_byte(b);
				end
			end
			MODE_AMP: begin
				if (entity_slot(b) >= 0) begin
					mode = MODE_NAMED;
					take_byte = hold_byte(b);
				end else if (b == med_pkg::CH_HASH) begin
					mode = MODE_HASH;
					take_byte = hold_byte(b);
				end else begin
					take_byte = 1'b0;
				end
			end
			MODE_NAMED: begin
				idx = (held_cnt >= 2) ? entity_slot(held[1]) : -1;
				pos = int'(held_cnt) - 1;
				if (idx < 0 || pos > 4) begin
					take_byte = 1'b0;
				end else if (pos < entity_name[idx].len()) begin
					if (b != entity_name[idx][pos]) begin
						take_byte = 1'b0;
					end else begin
						take_byte = hold_byte(b);
					end
				end else if (pos == entity_name[idx].len() && b == med_pkg::CH_SEMI) begin
					put_byte(entity_char[idx]);
					drop_match();
				end else begin
					take_byte = 1'b0;
				end
			end
			MODE_HASH: begin
				if (b >= med_pkg::CH_0 && b <= med_pkg::CH_9) begin
					code_acc = 32'(b - med_pkg::CH_0);
					mode = MODE_DEC;
					take_byte = hold_byte(b);
				end else if (b == med_pkg::CH_X) begin
					code_acc = 32'd0;
					mode = MODE_HEX;
					take_byte = hold_byte(b);
				end else begin
					take_byte = 1'b0;
				end
			end
			MODE_DEC, MODE_HEX: begin
				digits = int'(held_cnt) - ((mode == MODE_DEC) ? 2 : 3);
				v = digit_value(b, mode == MODE_HEX);
				if (v >= 0) begin
					if (digits >= MAX_DIGITS) begin
						take_byte = 1'b0;
					end else begin
						code_acc = code_acc * ((mode == MODE_DEC) ? 32'd10 : 32'd16) + 32'(v);
						take_byte = hold_byte(b);
					end
				end else if (b == med_pkg::CH_SEMI && digits > 0 && code_acc != 32'd0) begin
					put_code_point(code_acc);
					drop_match();
				end else begin
					take_byte = 1'b0;
				end
			end
			default: take_byte = 1'b0;
		endcase
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < int'(held_cnt) && i < HOLD_DEPTH; i++) begin
			put_byte(held[i]);
		end
		drop_match();
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		step_out.delete();
		if (!take_byte(b)) begin
			flush_held();
			void'(take_byte(b));
		end
		if (last) begin
			flush_held();
			if (step_out.size() == 0) begin
				add_step('{8'h00, 1'b0, 1'b1});
			end else begin
				step_out[$].last = 1'b1;
			end
		end
		expected_bytes = {expected_bytes, step_out};
	endfunction

	task automatic check_output();
		out_txn_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch("presence (nothing expected)", m_tdata, 0);
		end else begin
			want = expected_bytes.pop_front();
			if (m_tdata !== want.data) begin
				report_mismatch("byte_out", m_tdata, want.data);
			end
			if (m_tuser !== want.valid) begin
				report_mismatch("byte_valid", m_tuser, want.valid);
			end
			if (m_tlast !== want.last) begin
				report_mismatch("last_out", m_tlast, want.last);
			end
		end
		result_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_match();
			expected_bytes.delete();
			result_no = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				check_output();
			end
			pending <= expected_bytes.size();
		end
	end

endmodule

>>> verif/markup_entity_decoder_core_test.sv
// Testbench top for the markup entity decoder: clock, reset, input stimulus,
// output back-pressure and the verdict. Depends on med_pkg, the decoder RTL
// and med_stream_checker, which predicts and compares the output stream.
`timescale 1ns / 1ps

module markup_entity_decoder_core_test;

	localparam int MAX_DIGITS   = 8;
	localparam int RANDOM_ITEMS = 350;
	// Upper bound for the whole run, enforced by the watchdog.
	localparam int CYCLE_LIMIT  = 600000;
	// A failed match replays up to eleven held bytes; this covers it with margin.
	localparam int DRAIN_CYCLES = 40;
	localparam logic [7:0] CH_UPPER_X = 8'h58;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] byte_in
	logic       s_tlast  = 1'b0;    // last_in
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] byte_out
	logic       m_tuser;            // [0] byte_valid
	logic       m_tlast;            // last_out

	int fail_count;
	int pending;
	int tx_idle_pct = 37;
	int rx_idle_pct = 56;
	int items_sent  = 0;
	int cycle_count = 0;

	// Bytes of the next random fragment of text.
	logic [7:0] burst [$];
	string      entity_name [4] = '{"lt", "gt", "amp", "quot"};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	markup_entity_decoder_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	med_stream_checker #(
		.MAX_DIGITS(MAX_DIGITS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// The receiver stalls at random; with a zero percentage it is always ready.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Offers one byte, possibly after a few idle cycles, and returns at the
	// clock edge where the transaction is accepted. The valid line stays high
	// into the next byte when no idle cycle follows.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], last_at_end && (i == s.len() - 1));
		end
	endtask

	function automatic void add_burst(input logic [7:0] b);
		burst = {burst, b};
	endfunction

	// Builds one fragment of text: a run of arbitrary bytes, a named entity or a
	// numeric reference, sometimes damaged so that the match breaks somewhere.
	task automatic build_burst();
		int          kind;
		int          idx;
		logic [31:0] code;
		logic [31:0] rest;
		logic [31:0] d;
		bit          hex;
		logic [7:0]  digs [$];
		burst.delete();
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			repeat ($urandom_range(1, 4)) begin
				add_burst(8'($urandom_range(0, 255)));
			end
		end else if (kind < 6) begin
			idx = $urandom_range(0, 3);
			add_burst(med_pkg::CH_AMP);
			for (int k = 0; k < entity_name[idx].len(); k++) begin
				add_burst(entity_name[idx][k]);
			end
			add_burst(med_pkg::CH_SEMI);
		end else begin
			// Pick the code point by UTF-8 length, including the range above
			// the largest code point, which the block swallows.
			case ($urandom_range(0, 4))
				0:       code = $urandom_range(1, 32'h7F);
				1:       code = $urandom_range(32'h80, 32'h7FF);
				2:       code = $urandom_range(32'h800, 32'hFFFF);
				3:       code = $urandom_range(32'h10000, 32'h10FFFF);
				default: code = $urandom_range(32'h110000, 32'hFFFF_FFFF);
			endcase
			// A zero code point must fail and come out literally.
			if ($urandom_range(0, 7) == 0) begin
				code = 32'd0;
			end
			hex  = $urandom_range(0, 1);
			rest = code;
			do begin
				d    = hex ? rest % 16 : rest % 10;
				rest = hex ? rest / 16 : rest / 10;
				if (d < 10) begin
					digs.push_front(med_pkg::CH_0 + 8'(d));
				end else if ($urandom_range(0, 1) == 1) begin
					digs.push_front(8'h61 + 8'(d - 10));
				end else begin
					digs.push_front(8'h41 + 8'(d - 10));
				end
			end while (rest != 0);
			// Leading zeros push long numbers past the digit limit now and then.
			repeat ($urandom_range(0, 2)) begin
				digs.push_front(med_pkg::CH_0);
			end
			add_burst(med_pkg::CH_AMP);
			add_burst(med_pkg::CH_HASH);
			if (hex) begin
				add_burst(med_pkg::CH_X);
			end
			foreach (digs[k]) begin
				add_burst(digs[k]);
			end
			add_burst(med_pkg::CH_SEMI);
		end
		// Most fragments stay intact; the rest get one damaged or missing byte.
		case ($urandom_range(0, 11))
			0: burst[$urandom_range(0, burst.size() - 1)] = 8'($urandom_range(0, 255));
			1: burst[$urandom_range(0, burst.size() - 1)] = med_pkg::CH_AMP;
			2: burst[$urandom_range(0, burst.size() - 1)] = med_pkg::CH_SEMI;
			3: burst[$urandom_range(0, burst.size() - 1)] = CH_UPPER_X;
			4: begin
				if (burst.size() > 1) begin
					void'(burst.pop_back());
				end
			end
			default: ;
		endcase
	endtask

	// Watchdog: a hung handshake or a missing output ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text. A named entity, then the lowest and highest byte
		// values as plain text.
		send_text("&lt;", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// A zero code point is replayed literally together with its semicolon.
		send_text("&#0;", 1'b0);
		// End of text in the middle of an entity flushes the held bytes.
		send_text("&g", 1'b1);
		// A code point beyond the Unicode range emits nothing, so the end of
		// text comes out as a bare end marker.
		send_text("&#x110000;", 1'b1);

		// Random text in three idling phases: the receiver idles more than the
		// sender first, then the other way round, then nobody idles.
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else if (items_sent >= RANDOM_ITEMS / 3) begin
				tx_idle_pct = 56;
				rx_idle_pct <= 37;
			end
			build_burst();
			foreach (burst[k]) begin
				send_byte(burst[k], $urandom_range(0, 24) == 0);
			end
			items_sent += burst.size();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		// Wait for every predicted byte, then a little longer so that any
		// stray output transaction is caught too.
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> markup_entity_decoder_core.f
rtl/core/med_pkg.sv
rtl/core/med_datapath.sv
rtl/core/med_ctrl.sv
rtl/core/markup_entity_decoder_core.sv
verif/med_stream_checker.sv
verif/markup_entity_decoder_core_test.sv
